[rtl/core/rgav_pkg.sv]
// Shared types and constants for the read/genome abundance vote block.
package rgav_pkg;

  localparam int MAX_GENOMES = 64;
  localparam int GENOME_W    = $clog2(MAX_GENOMES);
  localparam int READ_W      = 32;
  localparam int COORD_W     = 16;
  localparam int SUM_W       = 32;
  localparam int CFG_W       = 7;
  localparam int PROD_L_W    = SUM_W + CFG_W;
  localparam int PROD_R_W    = CFG_W + COORD_W;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 40;
  localparam int PERCENT     = 100;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_GENOMES   = 1'b1;

  localparam logic MODE_FRAG   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_VOTE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_OUT_RD,
    ST_OUT_SEND
  } state_t;

  typedef struct packed {
    logic capture;
    logic judge;
    logic vote;
    logic cnt_rd;
    logic cnt_wr;
    logic out_rd;
    logic out_next;
  } cmd_t;

  typedef struct packed {
    logic is_finish;
    logic close_read;
    logic out_last;
  } status_t;

endpackage

[rtl/core/rgav_ctrl.sv]
// Controller state machine for the abundance vote block.
module rgav_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  rgav_pkg::status_t sts,
  output rgav_pkg::cmd_t    cmd
);

  rgav_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgav_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      rgav_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = rgav_pkg::ST_JUDGE;
        end
      end
      rgav_pkg::ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = rgav_pkg::ST_VOTE;
      end
      rgav_pkg::ST_VOTE: begin
        cmd.vote = 1'b1;
        if (sts.close_read) begin
          state_next = rgav_pkg::ST_CNT_RD;
        end else if (sts.is_finish) begin
          state_next = rgav_pkg::ST_OUT_RD;
        end else begin
          state_next = rgav_pkg::ST_IDLE;
        end
      end
      rgav_pkg::ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = rgav_pkg::ST_CNT_WR;
      end
      rgav_pkg::ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = sts.is_finish ? rgav_pkg::ST_OUT_RD : rgav_pkg::ST_IDLE;
      end
      rgav_pkg::ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = rgav_pkg::ST_OUT_SEND;
      end
      rgav_pkg::ST_OUT_SEND: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (sts.out_last) begin
            state_next = rgav_pkg::ST_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = rgav_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = rgav_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/rgav_dp.sv]
// Datapath: read/group tracking, coverage test, vote and counter memory.
module rgav_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [rgav_pkg::CFG_W-1:0]        cfg_data,
  input  logic [rgav_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,
  output logic [rgav_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  rgav_pkg::cmd_t                    cmd,
  output rgav_pkg::status_t                 sts
);

  localparam int GW = rgav_pkg::GENOME_W;
  localparam int CW = rgav_pkg::COORD_W;
  localparam int SW = rgav_pkg::SUM_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {{(SW+1-CW){1'b0}}, b};
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

  // configuration
  logic [rgav_pkg::CFG_W-1:0] coverage_threshold;
  logic [rgav_pkg::CFG_W-1:0] genomes_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      coverage_threshold <= '0;
      genomes_in_use     <= rgav_pkg::CFG_W'(rgav_pkg::MAX_GENOMES);
    end else if (cfg_we) begin
      case (cfg_index)
        rgav_pkg::REG_THRESHOLD: coverage_threshold <= cfg_data;
        rgav_pkg::REG_GENOMES:   genomes_in_use     <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured word
  logic                          it_mode;
  logic [rgav_pkg::READ_W-1:0]   it_rid;
  logic [GW-1:0]                 it_gid;
  logic [CW-1:0]                 it_xe;
  logic [CW-1:0]                 it_len;
  logic [CW-1:0]                 it_ident;
  logic                          it_kept;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode  <= s_axis_tuser;
      it_rid   <= s_axis_tdata[31:0];
      it_gid   <= s_axis_tdata[37:32];
      it_xe    <= s_axis_tdata[53:38];
      it_len   <= s_axis_tdata[69:54];
      it_ident <= s_axis_tdata[85:70];
      it_kept  <= s_axis_tdata[86];
    end
  end

  // tracking state
  logic                          started;
  logic [rgav_pkg::READ_W-1:0]   current_read;
  logic [GW-1:0]                 current_genome;
  logic [CW-1:0]                 read_extent;
  logic [SW-1:0]                 group_coverage;
  logic [SW-1:0]                 group_identity_sum;
  logic [SW-1:0]                 best_identity;
  logic [GW-1:0]                 best_genome;
  logic                          best_valid;

  logic                          new_read;
  logic                          new_genome;
  logic [CW-1:0]                 ext_max;
  logic [CW-1:0]                 judge_ext;
  logic                          closing_group;
  logic                          closing_read;

  assign new_read      = it_rid != current_read;
  assign new_genome    = it_gid != current_genome;
  assign ext_max       = (it_xe > read_extent) ? it_xe : read_extent;
  assign judge_ext     = (it_mode == rgav_pkg::MODE_FRAG && !new_read) ? ext_max
                                                                       : read_extent;
  assign closing_group = started && (it_mode == rgav_pkg::MODE_FINISH || new_read ||
                                     new_genome);
  assign closing_read  = started && (it_mode == rgav_pkg::MODE_FINISH || new_read);

  logic [rgav_pkg::PROD_L_W-1:0] prod_lhs;
  logic [rgav_pkg::PROD_R_W-1:0] prod_rhs;

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      prod_lhs <= rgav_pkg::PROD_L_W'(group_coverage) *
                  rgav_pkg::PROD_L_W'(rgav_pkg::PERCENT);
      prod_rhs <= rgav_pkg::PROD_R_W'(coverage_threshold) *
                  rgav_pkg::PROD_R_W'(judge_ext);
    end
  end

  logic group_pass;
  logic group_better;

  assign group_pass   = (prod_lhs > rgav_pkg::PROD_L_W'(prod_rhs)) &&
                        (group_identity_sum != '0);
  assign group_better = !best_valid || (group_identity_sum > best_identity) ||
                        (group_identity_sum == best_identity &&
                         current_genome < best_genome);

  logic [SW-1:0] start_cov;
  logic [SW-1:0] start_ident;

  assign start_cov   = it_kept ? SW'(it_len) : '0;
  assign start_ident = it_kept ? SW'(it_ident) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      started            <= 1'b0;
      current_read       <= '0;
      current_genome     <= '0;
      read_extent        <= '0;
      group_coverage     <= '0;
      group_identity_sum <= '0;
      best_identity      <= '0;
      best_genome        <= '0;
      best_valid         <= 1'b0;
    end else if (cmd.vote) begin
      if (closing_group && group_pass && group_better) begin
        best_identity <= group_identity_sum;
        best_genome   <= current_genome;
        best_valid    <= 1'b1;
      end
      if (it_mode == rgav_pkg::MODE_FINISH) begin
        started            <= 1'b0;
        current_read       <= '0;
        current_genome     <= '0;
        read_extent        <= '0;
        group_coverage     <= '0;
        group_identity_sum <= '0;
      end else if (!started || new_read) begin
        started            <= 1'b1;
        current_read       <= it_rid;
        read_extent        <= it_xe;
        current_genome     <= it_gid;
        group_coverage     <= start_cov;
        group_identity_sum <= start_ident;
      end else begin
        read_extent <= ext_max;
        if (new_genome) begin
          current_genome     <= it_gid;
          group_coverage     <= start_cov;
          group_identity_sum <= start_ident;
        end else if (it_kept) begin
          group_coverage     <= sat_add(group_coverage, it_len);
          group_identity_sum <= sat_add(group_identity_sum, it_ident);
        end
      end
    end else if (cmd.cnt_wr) begin
      best_identity <= '0;
      best_genome   <= '0;
      best_valid    <= 1'b0;
    end
  end

  // counter memory, entries read as zero until first written
  logic [SW-1:0]                    cnt_mem [rgav_pkg::MAX_GENOMES];
  logic [rgav_pkg::MAX_GENOMES-1:0] cnt_valid;
  logic [SW-1:0]                    rd_data;
  logic                             rd_valid;
  logic [GW-1:0]                    rd_addr;
  logic [GW-1:0]                    out_idx;
  logic [SW-1:0]                    cnt_value;
  logic [SW-1:0]                    cnt_inc;

  assign rd_addr   = cmd.cnt_rd ? best_genome : out_idx;
  assign cnt_value = rd_valid ? rd_data : '0;
  assign cnt_inc   = (cnt_value == {SW{1'b1}}) ? cnt_value : cnt_value + SW'(1);

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd || cmd.out_rd) begin
      rd_data <= cnt_mem[rd_addr];
    end
    if (cmd.cnt_wr && best_valid) begin
      cnt_mem[best_genome] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.cnt_rd || cmd.out_rd) begin
        rd_valid <= cnt_valid[rd_addr];
      end
      if (cmd.cnt_wr && best_valid) begin
        cnt_valid[best_genome] <= 1'b1;
      end
    end
  end

  // readout
  logic [GW-1:0] last_idx;

  always_comb begin
    if (genomes_in_use == '0) begin
      last_idx = '0;
    end else if (genomes_in_use > rgav_pkg::CFG_W'(rgav_pkg::MAX_GENOMES)) begin
      last_idx = GW'(rgav_pkg::MAX_GENOMES - 1);
    end else begin
      last_idx = GW'(genomes_in_use - rgav_pkg::CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_idx <= '0;
    end else if (cmd.capture) begin
      out_idx <= '0;
    end else if (cmd.out_next) begin
      out_idx <= out_idx + GW'(1);
    end
  end

  assign m_axis_tdata = {(rgav_pkg::OUT_DATA_W - SW - GW)'(0), cnt_value, out_idx};
  assign m_axis_tlast = out_idx == last_idx;

  assign sts.is_finish  = it_mode == rgav_pkg::MODE_FINISH;
  assign sts.close_read = closing_read;
  assign sts.out_last   = out_idx == last_idx;

endmodule

[rtl/core/read_genome_abundance_vote.sv]
// Top level of the read/genome abundance vote block.
//
// Input stream s_axis: one word per fragment or finish request. tuser is the mode
// (0 fragment, 1 finish). Fragments come sorted by read, then by genome.
// Output stream m_axis: on finish, one word per genome counter, index 0 up to
// genomes_in_use-1 (clamped to 1..64), tlast on the final one.
// Config port: cfg_we/cfg_index/cfg_data; index 0 coverage_threshold,
// index 1 genomes_in_use. Write only while the block is idle.
// Sequencing: one word in flight at a time. A fragment is captured, judged and
// voted; one that closes a read adds a read-modify-write of the counter memory.
// A finish takes the same steps, then per counter word a registered memory read
// and then the output word. s_axis_tready is low until done.
// A stalled receiver holds the current output word; nothing else advances.
// Reset: sync, active high; clears tracking, config to defaults and all
// counters to zero at once (per-entry valid bits), ready the next cycle.
module read_genome_abundance_vote (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rgav_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // read_id, genome_id, x_end, frag_length, identities, kept
  input  logic [rgav_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // genome_index, abundance
  output logic [rgav_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);

  rgav_pkg::cmd_t    cmd;
  rgav_pkg::status_t sts;

  rgav_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  rgav_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cmd          (cmd),
    .sts          (sts)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while output word pending");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while busy");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after final counter word");

endmodule
